// ----- src/bed_pkg.sv -----
// ----------------------------------------------------------------------------
// bed_pkg: shared types and constants of the button event debouncer
// Phase and event codes, register map, per-button state record and the
// wrap-safe time compare.
// ----------------------------------------------------------------------------
`default_nettype none

package bed_pkg;

    localparam int NUM_BUTTONS_DEF = 4;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] SETTLE_RST    = 16'd15;
    localparam logic [15:0] REPEAT_GAP_RST = 16'd200;
    localparam logic [15:0] HOLD_PER_RST  = 16'd1000;

    localparam logic [31:0] REACH_LIMIT = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CHECK = 3'd1,
        PH_DOWN  = 3'd2,
        PH_HOLD  = 3'd3,
        PH_UP    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_DOWN  = 2'd0,
        EV_HOLD  = 2'd1,
        EV_UP    = 2'd2,
        EV_CLICK = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        REG_MASK     = 2'd0,
        REG_SETTLE   = 2'd1,
        REG_GAP      = 2'd2,
        REG_HOLD_PER = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [3:0]  active_level_mask;
        logic [15:0] settle_ms;
        logic [15:0] repeat_gap_ms;
        logic [15:0] hold_period_ms;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] deadline_ms;
        logic [7:0]  press_count;
        logic [31:0] last_hold_ms;
    } btn_state_t;

    // true once now has reached or passed mark, modulo 2^32
    function automatic logic reached(logic [31:0] now, logic [31:0] mark);
        logic [31:0] diff;
        diff = now - mark;
        return diff < REACH_LIMIT;
    endfunction

endpackage

`default_nettype wire

// ----- src/button_event_debouncer.sv -----
// ----------------------------------------------------------------------------
// button_event_debouncer: per-button press, hold, release and click events
// Polls of up to NUM_BUTTONS buttons update a per-button state record kept
// in a small synchronous memory and raise debounced button events.
// ----------------------------------------------------------------------------
// One poll is accepted per clock cycle while the output stage can take its
// events. A poll is read from the state memory on acceptance, updated and
// written back by the update stage; a poll of the same button in the next
// cycle takes the new record from a forwarding register, so any mix of
// buttons runs at full rate. Polls that raise one event or none keep that
// rate; a release raises press-up and click as two beats, and a later poll
// that raises an event waits for the click. Entries read as idle with zero
// counters after reset through per-entry valid bits; there is no clearing pass.
`default_nettype none

module button_event_debouncer #(
    parameter int NUM_BUTTONS = bed_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bed_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [bed_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [bed_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready,
    // polls
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [39:0]                   s_tdata,  // pin_level, now_ms, zero pad
    input  wire logic [1:0]                    s_tuser,  // button_index
    // events
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [15:0]                   m_tdata,  // event_button, repeat_count, pad
    output logic      [1:0]                    m_tuser,  // event_code
    output logic                               m_tlast   // last_of_run
);
    import bed_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    cfg_t cfg;

    bed_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state memory
    btn_state_t mem [NUM_BUTTONS];
    btn_state_t rd_data_reg;
    logic [NUM_BUTTONS-1:0] valid_reg;

    // forwarding of the latest write
    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_addr_reg;
    btn_state_t       fwd_data_reg;

    // update stage
    logic        s1_valid_reg;
    logic [1:0]  s1_btn_reg;
    logic        s1_pin_reg;
    logic [31:0] s1_now_reg;

    // output stage
    logic        out_valid_reg;
    logic        pend_click_reg;
    logic [1:0]  obtn_reg;
    logic [7:0]  ocnt_reg;
    event_t      ocode_reg;

    logic             in_fire;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] s1_addr;
    logic             in_range;
    logic             active;
    logic             fwd_hit;
    btn_state_t       cur;
    btn_state_t       nxt;
    phase_t           phase_next;
    logic [1:0]       ev_n;
    event_t           ev_code;
    logic [31:0]      held;
    logic [31:0]      since_hold;
    logic             out_free;
    logic             out_pop;
    logic             s1_commit;
    logic             wr_en;

    assign in_fire  = s_tvalid && s_tready;
    assign rd_addr  = IDX_W'(s_tuser);
    assign s1_addr  = IDX_W'(s1_btn_reg);
    assign in_range = (32'(s1_btn_reg) < NUM_BUTTONS);
    assign active   = (s1_pin_reg == cfg.active_level_mask[s1_btn_reg]);
    assign fwd_hit  = fwd_valid_reg && (fwd_addr_reg == s1_addr);

    always_comb
    begin
        if (fwd_hit)
            cur = fwd_data_reg;
        else if (valid_reg[s1_addr])
            cur = rd_data_reg;
        else
            cur = '0;
    end

    assign held       = s1_now_reg - cur.deadline_ms;
    assign since_hold = held - cur.last_hold_ms;

    // next phase
    always_comb
    begin
        unique case (cur.phase)
            PH_CHECK:
            begin
                if (!active)
                    phase_next = PH_IDLE;
                else if (reached(s1_now_reg, cur.deadline_ms))
                    phase_next = PH_DOWN;
                else
                    phase_next = PH_CHECK;
            end
            PH_DOWN: phase_next = PH_HOLD;
            PH_HOLD: phase_next = active ? PH_HOLD : PH_UP;
            PH_UP:   phase_next = PH_IDLE;
            default: phase_next = active ? PH_CHECK : PH_IDLE;
        endcase
    end

    // record update and events
    always_comb
    begin
        nxt       = cur;
        nxt.phase = phase_next;
        ev_n      = 2'd0;
        ev_code   = EV_DOWN;
        unique case (cur.phase)
            PH_CHECK: ;
            PH_DOWN:
            begin
                nxt.press_count  = cur.press_count + 8'd1;
                nxt.last_hold_ms = '0;
                nxt.deadline_ms  = s1_now_reg;
                ev_n             = 2'd1;
                ev_code          = EV_DOWN;
            end
            PH_HOLD:
            begin
                if (active && (since_hold >= {16'd0, cfg.hold_period_ms}))
                begin
                    nxt.last_hold_ms = held;
                    ev_n             = 2'd1;
                    ev_code          = EV_HOLD;
                end
            end
            PH_UP:
            begin
                nxt.deadline_ms = s1_now_reg + {16'd0, cfg.repeat_gap_ms};
                ev_n            = 2'd2;
                ev_code         = EV_UP;
            end
            default:
            begin
                if (active)
                    nxt.deadline_ms = s1_now_reg + {16'd0, cfg.settle_ms};
                else if ((cur.press_count != 8'd0) && reached(s1_now_reg, cur.deadline_ms))
                    nxt.press_count = '0;
            end
        endcase
        if (!in_range)
            ev_n = 2'd0;
    end

    assign out_pop   = out_valid_reg && m_tready;
    assign out_free  = !out_valid_reg || (m_tready && !pend_click_reg);
    assign s1_commit = s1_valid_reg && ((ev_n == 2'd0) || out_free);
    assign s_tready  = !s1_valid_reg || s1_commit;
    assign wr_en     = s1_commit && in_range;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, ocnt_reg, obtn_reg};
    assign m_tuser  = ocode_reg;
    assign m_tlast  = !pend_click_reg;

    // memory: read on accept, write back from the update stage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_addr] <= nxt;
        if (in_fire)
            rd_data_reg <= mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_btn_reg <= s_tuser;
            s1_pin_reg <= s_tdata[0];
            s1_now_reg <= s_tdata[32:1];
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= nxt;
        end
        if (s1_commit && (ev_n != 2'd0))
        begin
            obtn_reg  <= s1_btn_reg;
            ocnt_reg  <= nxt.press_count;
            ocode_reg <= ev_code;
        end
        else if (out_pop && pend_click_reg)
        begin
            ocode_reg <= EV_CLICK;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            fwd_valid_reg  <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_click_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[s1_addr] <= 1'b1;
                fwd_valid_reg      <= 1'b1;
            end
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_commit)
                s1_valid_reg <= 1'b0;
            if (s1_commit && (ev_n != 2'd0))
            begin
                out_valid_reg  <= 1'b1;
                pend_click_reg <= (ev_n == 2'd2);
            end
            else if (out_pop)
            begin
                if (pend_click_reg)
                    pend_click_reg <= 1'b0;
                else
                    out_valid_reg <= 1'b0;
            end
        end
    end

    // a pending click always sits behind a press-up beat
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_click_reg |-> (out_valid_reg && (ocode_reg == EV_UP)))
        else $error("click pending without press-up at the head");

    // the input side only stalls behind a held update stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled without a blocked update");

    // a press-down always leaves the button in hold
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_commit && (ev_n == 2'd1) && (ev_code == EV_DOWN)) |-> (nxt.phase == PH_HOLD))
        else $error("press-down did not move to hold");

    // a written entry is recorded for forwarding and marked valid
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (fwd_valid_reg && valid_reg[fwd_addr_reg]))
        else $error("write not recorded for forwarding");

endmodule

`default_nettype wire

// ----- src/bed_cfg.sv -----
// ----------------------------------------------------------------------------
// bed_cfg: configuration registers
// APB-style slave holding the active level mask and the three timing values.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bed_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [bed_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [bed_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready,
    output bed_pkg::cfg_t                      cfg
);
    import bed_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MASK:     cfg_next.active_level_mask = pwdata[3:0];
                REG_SETTLE:   cfg_next.settle_ms         = pwdata[15:0];
                REG_GAP:      cfg_next.repeat_gap_ms     = pwdata[15:0];
                REG_HOLD_PER: cfg_next.hold_period_ms    = pwdata[15:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MASK:     prdata = {28'd0, cfg_reg.active_level_mask};
            REG_SETTLE:   prdata = {16'd0, cfg_reg.settle_ms};
            REG_GAP:      prdata = {16'd0, cfg_reg.repeat_gap_ms};
            REG_HOLD_PER: prdata = {16'd0, cfg_reg.hold_period_ms};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_level_mask <= 4'd0;
            cfg_reg.settle_ms         <= SETTLE_RST;
            cfg_reg.repeat_gap_ms     <= REPEAT_GAP_RST;
            cfg_reg.hold_period_ms    <= HOLD_PER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for button_event_debouncer
// Drives button polls on the input stream and checks every event beat
// against an in-bench per-button state machine. The polls are directed
// presses and releases first, then random press and release gestures under
// several register settings. Both stream sides pause at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bed_pkg::*;

    localparam int NBTN        = 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0] button;
        event_t     code;
        logic [7:0] count;
        logic       last;
    } btn_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;  // pin_level, now_ms, zero pad
    logic [1:0]  s_tuser = '0;  // button_index

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;       // event_button, repeat_count, pad
    logic [1:0]  m_tuser;       // event_code
    logic        m_tlast;

    button_event_debouncer #(.NUM_BUTTONS(NBTN)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #4 clk = ~clk;

    // register copy
    logic [3:0]  cfg_mask = 4'd0;
    logic [15:0] cfg_settle = SETTLE_RST;
    logic [15:0] cfg_gap = REPEAT_GAP_RST;
    logic [15:0] cfg_hold = HOLD_PER_RST;

    // per-button machine copy
    phase_t      btn_phase     [NBTN];
    logic [31:0] btn_deadline  [NBTN];
    logic [7:0]  btn_presses   [NBTN];
    logic [31:0] btn_last_hold [NBTN];

    btn_event_t pending_events[$];
    int         error_count = 0;
    int         cycle_count = 0;

    // sender burst control
    bit gaps_enable = 1'b0;
    int burst_left = 0;

    // gesture generator state
    bit          gesture_pressed [NBTN];
    int          gesture_left    [NBTN];
    logic [31:0] btn_time        [NBTN];

    initial
    begin
        for (int b = 0; b < NBTN; b++)
        begin
            btn_phase[b] = PH_IDLE;
            btn_deadline[b] = '0;
            btn_presses[b] = '0;
            btn_last_hold[b] = '0;
            gesture_pressed[b] = 1'b0;
            gesture_left[b] = 0;
            btn_time[b] = $urandom;
        end
    end

    function automatic logic is_due(input logic [31:0] now, input logic [31:0] mark);
        logic [31:0] diff;
        diff = now - mark;
        return diff < REACH_LIMIT;
    endfunction

    task automatic expect_event(input logic [1:0] b, input event_t code, input logic last);
        btn_event_t ev;
        ev.button = b;
        ev.code = code;
        ev.count = btn_presses[b];
        ev.last = last;
        pending_events.push_back(ev);
    endtask

    // one step of the polled button's machine; queues the events it raises
    task automatic predict_button_events(input logic [1:0] b, input logic pin,
                                         input logic [31:0] now);
        logic        active;
        logic [31:0] held;
        active = (pin == cfg_mask[b]);
        case (btn_phase[b])
            PH_CHECK:
            begin
                if (!active)
                    btn_phase[b] = PH_IDLE;
                else if (is_due(now, btn_deadline[b]))
                    btn_phase[b] = PH_DOWN;
            end
            PH_DOWN:
            begin
                btn_presses[b] = btn_presses[b] + 8'd1;
                btn_last_hold[b] = '0;
                btn_deadline[b] = now;
                expect_event(b, EV_DOWN, 1'b1);
                btn_phase[b] = PH_HOLD;
            end
            PH_HOLD:
            begin
                if (active)
                begin
                    held = now - btn_deadline[b];
                    if (held - btn_last_hold[b] >= {16'd0, cfg_hold})
                    begin
                        expect_event(b, EV_HOLD, 1'b1);
                        btn_last_hold[b] = held;
                    end
                end
                else
                begin
                    btn_phase[b] = PH_UP;
                end
            end
            PH_UP:
            begin
                expect_event(b, EV_UP, 1'b0);
                expect_event(b, EV_CLICK, 1'b1);
                btn_deadline[b] = now + {16'd0, cfg_gap};
                btn_phase[b] = PH_IDLE;
            end
            default:
            begin
                if (active)
                begin
                    btn_deadline[b] = now + {16'd0, cfg_settle};
                    btn_phase[b] = PH_CHECK;
                end
                else
                begin
                    btn_phase[b] = PH_IDLE;
                    if (btn_presses[b] != 8'd0 && is_due(now, btn_deadline[b]))
                        btn_presses[b] = 8'd0;
                end
            end
        endcase
    endtask

    task automatic send_poll(input logic [1:0] b, input logic pin, input logic [31:0] now);
        int gap;
        if (gaps_enable && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            // now and then a long run with no gap at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, now, pin};
        s_tuser <= b;
        do
            @(posedge clk);
        while (!s_tready);
        predict_button_events(b, pin, now);
    endtask

    // wait for every queued event, then let in-flight polls drain
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MASK:     cfg_mask = value[3:0];
            REG_SETTLE:   cfg_settle = value[15:0];
            REG_GAP:      cfg_gap = value[15:0];
            REG_HOLD_PER: cfg_hold = value[15:0];
            default:      ;
        endcase
    endtask

    task automatic load_settings(input logic [3:0] mask, input logic [15:0] settle,
                                 input logic [15:0] gap, input logic [15:0] hold);
        wait_quiet();
        write_reg(REG_MASK, {28'd0, mask});
        write_reg(REG_SETTLE, {16'd0, settle});
        write_reg(REG_GAP, {16'd0, gap});
        write_reg(REG_HOLD_PER, {16'd0, hold});
    endtask

    function automatic logic [31:0] advance_time(input logic [31:0] t);
        case ($urandom_range(0, 19))
            0:       return $urandom;
            1, 2, 3: return t + cfg_settle + $urandom_range(0, 3);
            4, 5, 6: return t + cfg_hold + $urandom_range(0, 3);
            7, 8:    return t + cfg_gap + $urandom_range(0, 3);
            default: return t + $urandom_range(0, 12);
        endcase
    endfunction

    // reset settings, pressed level 0: settle across the time wrap, bounce, hold,
    // release, repeat count and its clearing after the gap
    task automatic test_default_press();
        logic [31:0] t;
        t = 32'hFFFF_FFF0;
        send_poll(2'd0, 1'b0, t);
        send_poll(2'd0, 1'b0, t + 32'd5);
        send_poll(2'd0, 1'b0, 32'hFFFF_FFFF);
        send_poll(2'd0, 1'b1, 32'd0);
        send_poll(2'd0, 1'b0, 32'd999);
        send_poll(2'd0, 1'b0, 32'd1000);
        send_poll(2'd0, 1'b0, 32'd3500);
        send_poll(2'd0, 1'b1, 32'd3600);
        send_poll(2'd0, 1'b1, 32'd3601);
        send_poll(2'd0, 1'b0, 32'd3700);
        send_poll(2'd0, 1'b1, 32'd3705);
        send_poll(2'd0, 1'b0, 32'd3710);
        send_poll(2'd0, 1'b0, 32'd3725);
        send_poll(2'd1, 1'b1, 32'd3726);
        send_poll(2'd0, 1'b0, 32'd3726);
        send_poll(2'd0, 1'b1, 32'd3730);
        send_poll(2'd0, 1'b0, 32'd3731);
        send_poll(2'd0, 1'b1, 32'd4000);
    endtask

    // pressed level 1, no settle time and zero hold period
    task automatic test_zero_hold();
        logic [31:0] t;
        load_settings(4'hF, 16'd0, 16'd0, 16'd0);
        t = 32'h8000_0000;
        send_poll(2'd3, 1'b1, t);
        send_poll(2'd3, 1'b1, t);
        send_poll(2'd2, 1'b0, t);
        send_poll(2'd3, 1'b1, t + 32'd1);
        send_poll(2'd3, 1'b1, t + 32'd1);
        send_poll(2'd3, 1'b1, t + 32'd2);
        send_poll(2'd3, 1'b0, t + 32'd3);
        send_poll(2'd3, 1'b0, 32'h7FFF_FFFF);
    endtask

    task automatic run_random_phase(input logic [3:0] mask, input logic [15:0] settle,
                                    input logic [15:0] gap, input logic [15:0] hold,
                                    input int polls);
        logic [1:0] b;
        logic       pin;
        load_settings(mask, settle, gap, hold);
        gaps_enable = 1'b1;
        burst_left = 0;
        for (int i = 0; i < polls; i++)
        begin
            b = 2'($urandom_range(0, NBTN - 1));
            if (gesture_left[b] == 0)
            begin
                gesture_pressed[b] = !gesture_pressed[b];
                gesture_left[b] = gesture_pressed[b] ? $urandom_range(2, 8)
                                                     : $urandom_range(1, 5);
            end
            gesture_left[b]--;
            pin = gesture_pressed[b] ? cfg_mask[b] : !cfg_mask[b];
            // contact bounce
            if ($urandom_range(0, 9) == 0)
                pin = !pin;
            btn_time[b] = advance_time(btn_time[b]);
            send_poll(b, pin, btn_time[b]);
        end
        gaps_enable = 1'b0;
    endtask

    task automatic test_random_settings();
        run_random_phase(4'hF, 16'd0, 16'd0, 16'd1, 90);
        run_random_phase(4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 90);
        run_random_phase(4'h5, 16'd10, 16'd50, 16'd30, 90);
        run_random_phase(4'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
                         16'($urandom_range(0, 300)), 16'($urandom_range(1, 100)), 90);
        run_random_phase(4'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
                         16'($urandom_range(0, 300)), 16'($urandom_range(1, 100)), 90);
        run_random_phase(4'hA, 16'd3, 16'd20, 16'd0, 90);
    endtask

    // receiver: stall mode is drawn anew each time stall_cnt returns to zero, mode 0 never stalls
    int stall_mode = 0;
    int stall_cnt = 0;

    always @(posedge clk)
    begin
        if (stall_cnt == 0)
            stall_mode = $urandom_range(0, 3);
        stall_cnt = (stall_cnt + 1) % 64;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (stall_cnt % 4 == 0);
            default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        btn_event_t exp_ev;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $display({"%0t: unexpected event beat, expected none, ",
                          "actual button %0d code %0d count %0d"},
                         $time, m_tdata[1:0], m_tuser, m_tdata[9:2]);
                error_count++;
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                check_field("event_button", exp_ev.button, m_tdata[1:0]);
                check_field("event_code", exp_ev.code, m_tuser);
                check_field("repeat_count", exp_ev.count, m_tdata[9:2]);
                check_field("last_of_run", exp_ev.last, m_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d events outstanding", $time, pending_events.size());
            $display("FAIL button_event_debouncer");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_press();
        test_zero_hold();
        test_random_settings();
        wait_quiet();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("PASS button_event_debouncer");
        else
            $display("FAIL button_event_debouncer");
        $finish;
    end

endmodule

`default_nettype wire
